[rtl/bale_pkg.sv]
// shared types, codes and constants of the bounded array list engine
`default_nettype none

package bale_pkg;

    // default configuration
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // field widths at the ports
    localparam int CMD_W     = 4;
    localparam int POS_W     = 7;
    localparam int POS2_W    = 6;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 3;
    localparam int DOUT_W    = 32;
    localparam int COUNT_W   = 7;

    // depth of the command queue between front and back
    localparam int JOB_QDEPTH = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 4'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_INS_AT    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_REM_FRONT = 4'd3;
    localparam logic [CMD_W-1:0] CMD_REM_BACK  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_REM_AT    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_READ      = 4'd6;
    localparam logic [CMD_W-1:0] CMD_WRITE     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_SWAP      = 4'd8;
    localparam logic [CMD_W-1:0] CMD_FIND      = 4'd9;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    // operation classes after decode
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_INS   = 3'd0;
    localparam logic [OP_W-1:0] OP_REM   = 3'd1;
    localparam logic [OP_W-1:0] OP_READ  = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
    localparam logic [OP_W-1:0] OP_SWAP  = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND  = 3'd5;
    localparam logic [OP_W-1:0] OP_BAD   = 3'd6;

    // where an insert or removal takes place
    localparam int WHERE_W = 2;
    localparam logic [WHERE_W-1:0] WHERE_FRONT = 2'd0;
    localparam logic [WHERE_W-1:0] WHERE_BACK  = 2'd1;
    localparam logic [WHERE_W-1:0] WHERE_AT    = 2'd2;

    // input item
    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [POS_W-1:0]          position;
        logic [POS2_W-1:0]         second_position;
        logic signed [VALUE_W-1:0] value;
    } t_item;

    // result item
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DOUT_W-1:0] data;
        logic [COUNT_W-1:0]       count;
    } t_result;

    // classified command handed from front to back
    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [WHERE_W-1:0]        where;
        logic [POS_W-1:0]          position;
        logic [POS2_W-1:0]         second_position;
        logic signed [VALUE_W-1:0] value;
    } t_job;

endpackage

`default_nettype wire

[rtl/bale_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none

module bale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/bale_front.sv]
// front end: takes items, decodes the command and queues it for the back end
`default_nettype none

module bale_front
    import bale_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    output logic       o_full,
    input  wire t_item i_item,
    output logic       o_job_valid,
    output t_job       o_job,
    input  wire logic  i_job_take
);

    localparam int QPW = (JOB_QDEPTH > 1) ? $clog2(JOB_QDEPTH) : 1;
    localparam int QCW = $clog2(JOB_QDEPTH + 1);

    logic [QPW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0] r_fill, n_fill;
    t_job           r_slot [JOB_QDEPTH];
    t_job           w_job;
    logic           w_push_ok;
    logic           w_take_ok;

    // command decode
    always_comb begin
        w_job.position        = i_item.position;
        w_job.second_position = i_item.second_position;
        w_job.value           = i_item.value;
        w_job.op              = OP_BAD;
        w_job.where           = WHERE_AT;
        unique case (i_item.cmd)
            CMD_INS_FRONT: begin
                w_job.op    = OP_INS;
                w_job.where = WHERE_FRONT;
            end
            CMD_INS_BACK: begin
                w_job.op    = OP_INS;
                w_job.where = WHERE_BACK;
            end
            CMD_INS_AT: begin
                w_job.op = OP_INS;
            end
            CMD_REM_FRONT: begin
                w_job.op    = OP_REM;
                w_job.where = WHERE_FRONT;
            end
            CMD_REM_BACK: begin
                w_job.op    = OP_REM;
                w_job.where = WHERE_BACK;
            end
            CMD_REM_AT: begin
                w_job.op = OP_REM;
            end
            CMD_READ:  w_job.op = OP_READ;
            CMD_WRITE: w_job.op = OP_WRITE;
            CMD_SWAP:  w_job.op = OP_SWAP;
            CMD_FIND:  w_job.op = OP_FIND;
            default:   w_job.op = OP_BAD;
        endcase
    end

    // queue handshake
    assign o_full      = (r_fill == QCW'(JOB_QDEPTH));
    assign o_job_valid = (r_fill != '0);
    assign o_job       = r_slot[r_rd_ptr];
    assign w_push_ok   = i_push && !o_full;
    assign w_take_ok   = i_job_take && o_job_valid;

    // pointer and fill update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (w_push_ok) begin
            n_wr_ptr = (r_wr_ptr == QPW'(JOB_QDEPTH - 1)) ? '0 : r_wr_ptr + QPW'(1);
        end
        if (w_take_ok) begin
            n_rd_ptr = (r_rd_ptr == QPW'(JOB_QDEPTH - 1)) ? '0 : r_rd_ptr + QPW'(1);
        end
        if (w_push_ok && !w_take_ok) begin
            n_fill = r_fill + QCW'(1);
        end else if (!w_push_ok && w_take_ok) begin
            n_fill = r_fill - QCW'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_slot[r_wr_ptr] <= w_job;
        end
    end

endmodule

`default_nettype wire

[rtl/bale_back.sv]
// back end: runs one command at a time against the element ram
`default_nettype none

module bale_back
    import bale_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_job_take,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_result   o_result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXEC     = 4'd1;
    localparam logic [3:0] S_INS_STEP = 4'd2;
    localparam logic [3:0] S_INS_MOVE = 4'd3;
    localparam logic [3:0] S_REM_CAP  = 4'd4;
    localparam logic [3:0] S_REM_STEP = 4'd5;
    localparam logic [3:0] S_REM_MOVE = 4'd6;
    localparam logic [3:0] S_READ_CAP = 4'd7;
    localparam logic [3:0] S_SWAP_A   = 4'd8;
    localparam logic [3:0] S_SWAP_B   = 4'd9;
    localparam logic [3:0] S_SWAP_C   = 4'd10;
    localparam logic [3:0] S_FIND     = 4'd11;

    logic [3:0]            r_state, n_state;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_tmp;
    t_job                  r_job;
    logic                  r_out_valid;
    t_result               r_out;

    logic                  w_tmp_load;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [DATA_WIDTH-1:0] w_rd_data;
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [DATA_WIDTH-1:0] w_wr_data;

    logic                  w_fin;
    logic [STATUS_W-1:0]   w_fin_status;
    logic [DOUT_W-1:0]     w_fin_data;
    logic [CW-1:0]         w_fin_count;

    logic [DATA_WIDTH-1:0] w_word;
    logic [PW-1:0]         w_cnt_ext, w_p1_ext, w_p2_ext;
    logic                  w_p1_gt_cnt, w_p1_ge_cnt, w_p2_ge_cnt;
    logic                  w_cnt_zero, w_cnt_full;
    logic [CW-1:0]         w_cnt_m1;
    logic [CW-1:0]         w_idx_next;
    logic [AW-1:0]         w_p1_addr, w_p2_addr;
    logic [AW-1:0]         w_ins_pos, w_rem_pos;

    // stored word sign-extended or cut to the result width
    function automatic logic [DOUT_W-1:0] to_data(input logic [DATA_WIDTH-1:0] x);
        return DOUT_W'($signed(x));
    endfunction

    // element store
    bale_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // operand preparation and bounds checks
    assign w_word      = DATA_WIDTH'(r_job.value);
    assign w_cnt_ext   = PW'(r_count);
    assign w_p1_ext    = PW'(r_job.position);
    assign w_p2_ext    = PW'(r_job.second_position);
    assign w_p1_gt_cnt = (w_p1_ext > w_cnt_ext);
    assign w_p1_ge_cnt = (w_p1_ext >= w_cnt_ext);
    assign w_p2_ge_cnt = (w_p2_ext >= w_cnt_ext);
    assign w_cnt_zero  = (r_count == '0);
    assign w_cnt_full  = (r_count >= CW'(CAPACITY));
    assign w_cnt_m1    = r_count - CW'(1);
    assign w_idx_next  = CW'(r_idx) + CW'(1);
    assign w_p1_addr   = AW'(w_p1_ext);
    assign w_p2_addr   = AW'(w_p2_ext);

    // target index of an insert or removal
    always_comb begin
        unique case (r_job.where)
            WHERE_FRONT: begin
                w_ins_pos = '0;
                w_rem_pos = '0;
            end
            WHERE_BACK: begin
                w_ins_pos = AW'(r_count);
                w_rem_pos = AW'(w_cnt_m1);
            end
            default: begin
                w_ins_pos = w_p1_addr;
                w_rem_pos = w_p1_addr;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pos        = r_pos;
        o_job_take   = 1'b0;
        w_tmp_load   = 1'b0;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_idx;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_idx;
        w_wr_data    = w_rd_data;
        w_fin        = 1'b0;
        w_fin_status = ST_OK;
        w_fin_data   = '0;
        w_fin_count  = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid && (!r_out_valid || i_pop)) begin
                    o_job_take = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_job.op)
                    OP_INS: begin
                        priority if (r_job.where == WHERE_AT && w_p1_gt_cnt) begin
                            w_fin        = 1'b1;
                            w_fin_status = ST_BADPOS;
                        end else if (w_cnt_full) begin
                            w_fin        = 1'b1;
                            w_fin_status = ST_FULL;
                        end else begin
                            n_pos   = w_ins_pos;
                            n_idx   = AW'(r_count);
                            n_state = S_INS_STEP;
                        end
                    end
                    OP_REM: begin
                        priority if (w_cnt_zero) begin
                            w_fin        = 1'b1;
                            w_fin_status = ST_EMPTY;
                        end else if (r_job.where == WHERE_AT && w_p1_ge_cnt) begin
                            w_fin        = 1'b1;
                            w_fin_status = ST_BADPOS;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = w_rem_pos;
                            n_idx     = w_rem_pos;
                            n_state   = S_REM_CAP;
                        end
                    end
                    OP_READ: begin
                        if (w_p1_ge_cnt) begin
                            w_fin        = 1'b1;
                            w_fin_status = ST_BADPOS;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = w_p1_addr;
                            n_state   = S_READ_CAP;
                        end
                    end
                    OP_WRITE: begin
                        w_fin = 1'b1;
                        if (w_p1_ge_cnt) begin
                            w_fin_status = ST_BADPOS;
                        end else begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = w_p1_addr;
                            w_wr_data = w_word;
                        end
                    end
                    OP_SWAP: begin
                        if (w_p1_ge_cnt || w_p2_ge_cnt) begin
                            w_fin        = 1'b1;
                            w_fin_status = ST_BADPOS;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = w_p1_addr;
                            n_state   = S_SWAP_A;
                        end
                    end
                    OP_FIND: begin
                        if (w_cnt_zero) begin
                            w_fin        = 1'b1;
                            w_fin_status = ST_NOTFOUND;
                            w_fin_data   = '1;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = '0;
                            n_idx     = '0;
                            n_state   = S_FIND;
                        end
                    end
                    default: begin
                        w_fin        = 1'b1;
                        w_fin_status = ST_BADPOS;
                    end
                endcase
            end
            // shift entries up from the top down to the insert position
            S_INS_STEP: begin
                if (r_idx == r_pos) begin
                    w_wr_en     = 1'b1;
                    w_wr_addr   = r_pos;
                    w_wr_data   = w_word;
                    w_fin       = 1'b1;
                    w_fin_count = r_count + CW'(1);
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_idx - AW'(1);
                    n_state   = S_INS_MOVE;
                end
            end
            S_INS_MOVE: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx;
                n_idx     = r_idx - AW'(1);
                n_state   = S_INS_STEP;
            end
            // keep the removed entry, then shift later entries down
            S_REM_CAP: begin
                w_tmp_load = 1'b1;
                n_state    = S_REM_STEP;
            end
            S_REM_STEP: begin
                if (w_idx_next >= r_count) begin
                    w_fin       = 1'b1;
                    w_fin_data  = to_data(r_tmp);
                    w_fin_count = w_cnt_m1;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = AW'(w_idx_next);
                    n_state   = S_REM_MOVE;
                end
            end
            S_REM_MOVE: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx;
                n_idx     = r_idx + AW'(1);
                n_state   = S_REM_STEP;
            end
            S_READ_CAP: begin
                w_fin      = 1'b1;
                w_fin_data = to_data(w_rd_data);
            end
            // swap: hold first entry, copy second over it, then put first back
            S_SWAP_A: begin
                w_tmp_load = 1'b1;
                w_rd_en    = 1'b1;
                w_rd_addr  = w_p2_addr;
                n_state    = S_SWAP_B;
            end
            S_SWAP_B: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_p1_addr;
                n_state   = S_SWAP_C;
            end
            S_SWAP_C: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_p2_addr;
                w_wr_data = r_tmp;
                w_fin     = 1'b1;
            end
            // linear scan of the live entries, one per cycle
            S_FIND: begin
                priority if (w_rd_data == w_word) begin
                    w_fin      = 1'b1;
                    w_fin_data = DOUT_W'(r_idx);
                end else if (w_idx_next >= r_count) begin
                    w_fin        = 1'b1;
                    w_fin_status = ST_NOTFOUND;
                    w_fin_data   = '1;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = AW'(w_idx_next);
                    n_idx     = AW'(w_idx_next);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_fin) begin
            n_state = S_IDLE;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin) begin
                r_count     <= w_fin_count;
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_pos <= n_pos;
        if (o_job_take) begin
            r_job <= i_job;
        end
        if (w_tmp_load) begin
            r_tmp <= w_rd_data;
        end
        if (w_fin) begin
            r_out.status <= w_fin_status;
            r_out.data   <= w_fin_data;
            r_out.count  <= COUNT_W'(w_fin_count);
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

[rtl/bounded_array_list_engine.sv]
// Bounded ordered list of signed words with insert, remove, read, write,
// swap and find commands.
//
// Input side is a queue: drive i_item and push; the item is taken on a
// clock edge with push high and full low. Result side is a queue too:
// while empty is low o_result holds the oldest result (status, data and
// the live count after the command); pop takes it.
// A two-entry command queue after the decoder lets items arrive while
// the back end works and while a result waits to be popped.
// Insert and remove move each shifted entry with a read then a write,
// and find scans one entry a cycle.
// Commands run one at a time, with an idle state between commands.
// A stalled receiver holds the result; the back end waits with the next
// command and input items queue until full rises.
// Synchronous reset empties the list (count zero) and both queues; the
// element ram is not cleared, entries beyond the count are never read.
`default_nettype none

module bounded_array_list_engine
    import bale_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire t_item i_item,
    output logic       empty,
    input  wire logic  pop,
    output t_result    o_result
);

    logic w_job_valid;
    logic w_job_take;
    t_job w_job;

    // decode and queue
    bale_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_take  (w_job_take)
    );

    // execution against the element store
    bale_back #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_take  (w_job_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

[rtl/bale_checker.sv]
// port-level checks of the list engine and their binding to the top level
`default_nettype none

module bale_checker
    import bale_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    i_full,
    input wire logic    i_empty,
    input wire logic    i_pop,
    input wire t_result i_result
);

    // queues come out of reset empty
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> i_empty && !i_full)
        else $error("queues not clear after reset");

    // a waiting result stays put until popped
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && !i_pop |=> !i_empty && $stable(i_result))
        else $error("waiting result changed");

    // failed commands other than find carry zero data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && (i_result.status == ST_BADPOS || i_result.status == ST_FULL ||
                     i_result.status == ST_EMPTY) |-> i_result.data == '0)
        else $error("failed command with non-zero data");

    // a missed search reports minus one
    a_notfound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && i_result.status == ST_NOTFOUND |-> i_result.data == '1)
        else $error("missed search without minus one");

    // removal from an empty list leaves count zero
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && i_result.status == ST_EMPTY |-> i_result.count == '0)
        else $error("empty status with live entries");

endmodule

bind bounded_array_list_engine bale_checker u_bale_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_full   (full),
    .i_empty  (empty),
    .i_pop    (pop),
    .i_result (o_result)
);

`default_nettype wire

[tb/sv/bounded_array_list_engine_test.sv]
// self-checking testbench of the bounded array list engine, checked against its own list model
`timescale 1ns / 1ps

module bounded_array_list_engine_test;
    import bale_pkg::*;

    localparam int LIST_CAPACITY = CAPACITY_DEF;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 150;

    // codes past the last command, which the block must reject
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 4'd10;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 4'd15;

    localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    push    = 1'b0;
    logic    pop     = 1'b0;
    t_item   i_item  = '0;
    logic    full;
    logic    empty;
    t_result o_result;

    // list model state and the answers still to come
    logic signed [VALUE_W-1:0] list_words [LIST_CAPACITY];
    int unsigned live_count = 0;
    t_result     answer_queue [$];

    int mismatches    = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    bounded_array_list_engine u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // applies one command to the list model and returns its answer
    function automatic t_result apply_list_command(input t_item it);
        t_result     r;
        int unsigned n;
        int unsigned slot;
        logic signed [VALUE_W-1:0] held;
        r.status = ST_OK;
        r.data   = '0;
        n        = live_count;
        case (it.cmd)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
                if (it.cmd == CMD_INS_AT && it.position > n) begin
                    r.status = ST_BADPOS;
                end else if (n >= LIST_CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    slot = (it.cmd == CMD_INS_FRONT) ? 0 :
                           (it.cmd == CMD_INS_BACK) ? n : it.position;
                    for (int i = n; i > slot; i--) list_words[i] = list_words[i-1];
                    list_words[slot] = it.value;
                    live_count++;
                end
            end
            CMD_REM_FRONT, CMD_REM_BACK, CMD_REM_AT: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else if (it.cmd == CMD_REM_AT && it.position >= n) begin
                    r.status = ST_BADPOS;
                end else begin
                    slot = (it.cmd == CMD_REM_FRONT) ? 0 :
                           (it.cmd == CMD_REM_BACK) ? n - 1 : it.position;
                    r.data = list_words[slot];
                    for (int i = slot; i + 1 < n; i++) list_words[i] = list_words[i+1];
                    live_count--;
                end
            end
            CMD_READ: begin
                if (it.position >= n) r.status = ST_BADPOS;
                else r.data = list_words[it.position];
            end
            CMD_WRITE: begin
                if (it.position >= n) r.status = ST_BADPOS;
                else list_words[it.position] = it.value;
            end
            CMD_SWAP: begin
                if (it.position >= n || it.second_position >= n) begin
                    r.status = ST_BADPOS;
                end else begin
                    held = list_words[it.position];
                    list_words[it.position] = list_words[it.second_position];
                    list_words[it.second_position] = held;
                end
            end
            CMD_FIND: begin
                r.status = ST_NOTFOUND;
                r.data   = -32'sd1;
                for (int i = 0; i < n && r.status != ST_OK; i++) begin
                    if (list_words[i] == it.value) begin
                        r.status = ST_OK;
                        r.data   = 32'(i);
                    end
                end
            end
            default: begin
                r.status = ST_BADPOS;
            end
        endcase
        r.count = COUNT_W'(live_count);
        return r;
    endfunction

    function automatic t_item list_command(input logic [CMD_W-1:0] cmd,
                                           input int unsigned pos, input int unsigned pos2,
                                           input logic signed [VALUE_W-1:0] value);
        t_item it;
        it.cmd             = cmd;
        it.position        = POS_W'(pos);
        it.second_position = POS2_W'(pos2);
        it.value           = value;
        return it;
    endfunction

    // extremes, a few small values that repeat often, and random words
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return -32'sd1;
            4, 5, 6: return 32'($urandom_range(8)) - 32'sd4;
            default: return $urandom;
        endcase
    endfunction

    // sends one item, idling at random first; push stays high afterwards
    task automatic send_item(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        answer_queue.push_back(apply_list_command(it));
    endtask

    // sender pauses until every awaited answer has been taken
    task automatic wait_for_answers();
        push <= 1'b0;
        do @(posedge i_clk); while (answer_queue.size() != 0);
    endtask

    task automatic note_mismatch(input string what, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch, %s: expected status %0d data %0d count %0d, got status %0d data %0d count %0d",
                     what, want.status, want.data, want.count, got.status, got.data, got.count);
    endtask

    // receiver: pops at random
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result check against the oldest awaited answer
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (answer_queue.size() == 0) begin
                note_mismatch("result with nothing awaited", '0, o_result);
            end else begin
                want = answer_queue.pop_front();
                if (o_result.status != want.status || o_result.data != want.data ||
                    o_result.count != want.count)
                    note_mismatch("wrong field", want, o_result);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // every removal and access on an empty list, an out-of-range insert, plus unknown codes
    task automatic test_empty_list();
        send_item(list_command(CMD_REM_FRONT, 0, 0, '0));
        send_item(list_command(CMD_REM_BACK, 0, 0, '0));
        send_item(list_command(CMD_REM_AT, 0, 0, '0));
        send_item(list_command(CMD_READ, 0, 0, '0));
        send_item(list_command(CMD_WRITE, 0, 0, WORD_MAX));
        send_item(list_command(CMD_SWAP, 0, 0, '0));
        send_item(list_command(CMD_FIND, 0, 0, '0));
        send_item(list_command(CMD_INS_AT, 1, 0, '1));
        send_item(list_command(CMD_UNKNOWN_LO, 0, 0, '0));
        send_item(list_command(CMD_UNKNOWN_HI, 127, 63, '1));
        wait_for_answers();
    endtask

    // every command on a short list, with good and bad positions
    task automatic test_basic_edits();
        send_item(list_command(CMD_INS_FRONT, 0, 0, WORD_MIN));
        send_item(list_command(CMD_INS_BACK, 0, 0, WORD_MAX));
        send_item(list_command(CMD_INS_AT, 1, 0, '0));
        send_item(list_command(CMD_INS_AT, 3, 0, -32'sd1));
        send_item(list_command(CMD_INS_AT, 64, 0, 32'sd7));
        send_item(list_command(CMD_INS_AT, 127, 0, 32'sd7));
        send_item(list_command(CMD_READ, 0, 0, '0));
        send_item(list_command(CMD_READ, 3, 0, '0));
        send_item(list_command(CMD_READ, 4, 0, '0));
        send_item(list_command(CMD_WRITE, 1, 0, 32'sh5555_5555));
        send_item(list_command(CMD_WRITE, 4, 0, 32'sh2AAA_AAAA));
        send_item(list_command(CMD_SWAP, 0, 3, '0));
        send_item(list_command(CMD_SWAP, 1, 63, '0));
        send_item(list_command(CMD_SWAP, 64, 0, '0));
        send_item(list_command(CMD_FIND, 0, 0, WORD_MIN));
        send_item(list_command(CMD_FIND, 0, 0, 32'sh5555_5555));
        send_item(list_command(CMD_FIND, 0, 0, 32'sd12345));
        send_item(list_command(CMD_REM_AT, 4, 0, '0));
        send_item(list_command(CMD_REM_AT, 1, 0, '0));
        send_item(list_command(CMD_REM_FRONT, 0, 0, '0));
        send_item(list_command(CMD_REM_BACK, 0, 0, '0));
        send_item(list_command(CMD_REM_BACK, 0, 0, '0));
        wait_for_answers();
    endtask

    // fill to capacity, then the full and boundary cases
    task automatic test_full_list();
        while (live_count < LIST_CAPACITY)
            send_item(list_command(CMD_INS_BACK, 0, 0, pick_value()));
        send_item(list_command(CMD_INS_FRONT, 0, 0, 32'sd1));
        send_item(list_command(CMD_INS_BACK, 0, 0, 32'sd1));
        send_item(list_command(CMD_INS_AT, 64, 0, 32'sd1));
        send_item(list_command(CMD_INS_AT, 65, 0, 32'sd1));
        send_item(list_command(CMD_READ, 63, 0, '0));
        send_item(list_command(CMD_WRITE, 63, 0, 32'sh1234_5678));
        send_item(list_command(CMD_FIND, 0, 0, 32'sh1234_5678));
        send_item(list_command(CMD_SWAP, 0, 63, '0));
        send_item(list_command(CMD_READ, 64, 0, '0));
        send_item(list_command(CMD_REM_AT, 64, 0, '0));
        send_item(list_command(CMD_REM_AT, 0, 0, '0));
        send_item(list_command(CMD_INS_AT, 63, 0, WORD_MAX));
        wait_for_answers();
    endtask

    // random commands, mostly in range, with the count drifting up and down
    task automatic test_random_commands(input int n_items, input int send_pct,
                                        input int recv_pct);
        t_item it;
        bit    growing;
        int    roll;
        int    span;
        growing       = 1'b1;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (n_items) begin
            if (live_count >= LIST_CAPACITY - 2) growing = 1'b0;
            else if (live_count <= 2) growing = 1'b1;
            else if ($urandom_range(39) == 0) growing = !growing;
            roll = $urandom_range(99);
            if (roll < 3)
                it.cmd = CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
            else if (roll < (growing ? 48 : 18))
                it.cmd = CMD_W'($urandom_range(CMD_INS_FRONT, CMD_INS_AT));
            else if (roll < 63)
                it.cmd = CMD_W'($urandom_range(CMD_REM_FRONT, CMD_REM_AT));
            else
                it.cmd = CMD_W'($urandom_range(CMD_READ, CMD_FIND));
            // positions mostly valid for the command, sometimes anywhere
            span = (it.cmd <= CMD_INS_AT) ? live_count : live_count - 1;
            if (span >= 0 && $urandom_range(99) < 88)
                it.position = POS_W'($urandom_range(span));
            else
                it.position = POS_W'($urandom_range(127));
            if (live_count > 0 && $urandom_range(99) < 85)
                it.second_position = POS2_W'($urandom_range(live_count - 1));
            else
                it.second_position = POS2_W'($urandom_range(63));
            if (it.cmd == CMD_FIND && live_count > 0 && $urandom_range(99) < 60)
                it.value = list_words[$urandom_range(live_count - 1)];
            else
                it.value = pick_value();
            send_item(it);
        end
        wait_for_answers();
    endtask

    initial begin
        send_idle_pct = 37;
        recv_idle_pct = 48;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_basic_edits();
        test_full_list();
        test_random_commands(180, 37, 48);
        test_random_commands(180, 48, 37);
        test_random_commands(182, 0, 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && answer_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
